### sv/bir_pkg.sv
package bir_pkg;

	localparam int MAX_SRC_HEIGHT = 256;
	localparam int MAX_SRC_WIDTH  = 256;
	localparam int FRAC_BITS      = 16;

	localparam int POS_W   = 12;
	localparam int PIX_W   = 8;
	localparam int SRC_W   = 9;
	localparam int DST_W   = 13;
	localparam int LIM_W   = 13;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int ROW_AW   = $clog2(MAX_SRC_HEIGHT);
	localparam int COL_AW   = $clog2(MAX_SRC_WIDTH);
	localparam int FS_DEPTH = MAX_SRC_HEIGHT * MAX_SRC_WIDTH;
	localparam int FS_AW    = $clog2(FS_DEPTH);

	localparam int MUL_W     = POS_W + 1 + SRC_W;
	localparam int NUM_W     = MUL_W + FRAC_BITS - 1;
	localparam int DIVN_W    = NUM_W + (NUM_W % 2);
	localparam int DIV_STEPS = DIVN_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
	localparam int S_W       = DIVN_W + 1;
	localparam int FL_W      = S_W - FRAC_BITS;
	localparam int WGT_W     = FRAC_BITS + 1;
	localparam int WP_W      = 2 * WGT_W;
	localparam int ACC_W     = WP_W + PIX_W;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [1:0] {
		REG_SRC_HEIGHT = 2'd0,
		REG_SRC_WIDTH  = 2'd1,
		REG_DST_HEIGHT = 2'd2,
		REG_DST_WIDTH  = 2'd3
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_MAP  = 7'b0001000,
		ST_EDGE = 7'b0010000,
		ST_READ = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

endpackage

### sv/bir_ram.sv
module bir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/bir_div.sv
module bir_div
	import bir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DST_W-1:0]  divisor,
	output logic              busy,
	output logic [DIVN_W-1:0] quotient
);

	logic [DCNT_W-1:0] cnt_q;
	logic [DIVN_W-1:0] n_q;
	logic [DST_W-1:0]  rem_q;
	logic [DST_W-1:0]  d_q;

	logic [DIVN_W-1:0] n_nxt;
	logic [DST_W-1:0]  r_nxt;
	logic [DST_W:0]    r2;
	logic              ge;

	// two restoring steps per cycle
	always_comb begin
		n_nxt = n_q;
		r_nxt = rem_q;
		r2    = '0;
		ge    = 1'b0;
		for (int i = 0; i < 2; i++) begin
			r2 = {r_nxt, n_nxt[DIVN_W-1]};
			ge = (r2 >= {1'b0, d_q});
			if (ge) begin
				r2 = r2 - {1'b0, d_q};
			end
			r_nxt = r2[DST_W-1:0];
			n_nxt = {n_nxt[DIVN_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DCNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			n_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			n_q   <= n_nxt;
			rem_q <= r_nxt;
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = n_q;

endmodule

### sv/bilinear_image_resize_unit.sv
// Bilinear image resize with half-pixel centres over an on-chip frame store.
// Input channel: drive action/row/col/pixel_in with start; a beat is taken at
// a rising edge where start is high and busy is low.
// Load beats (action low) write pixel_in into the frame store in that same
// edge; busy stays low, so one load beat per cycle is taken. Loads outside
// the store are dropped.
// Compute beats (action high) raise busy through the multiply state, the
// shared-nothing radix-4 dividers (one per axis, two quotient bits per cycle),
// the map and edge states, four reads of the single-read-port frame store
// plus the weight and blend pipeline, and the rounding state. pixel_out with
// done appears in the cycle after the rounding state; busy is low then, so
// a new beat may be taken in that cycle.
// Output channel: done marks pixel_out for exactly one cycle; the receiver
// cannot stall it, so it must take every result beat.
// Configuration: APB writes to src_height (0x0), src_width (0x4),
// dst_height (0x8), dst_width (0xc); write only while idle.
// Reset: registers return to 256, control goes idle. The frame store is not
// cleared; every pixel must be loaded before it is used.
module bilinear_image_resize_unit
	import bir_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [POS_W-1:0]   row,
	input  logic [POS_W-1:0]   col,
	input  logic [PIX_W-1:0]   pixel_in,
	output logic               done,
	output logic [PIX_W-1:0]   pixel_out
);

	logic [SRC_W-1:0] src_height_q;
	logic [SRC_W-1:0] src_width_q;
	logic [DST_W-1:0] dst_height_q;
	logic [DST_W-1:0] dst_width_q;

	state_t state_q;
	logic   accept;
	logic   wr_en;

	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;

	logic [MUL_W-1:0]  mul_y;
	logic [MUL_W-1:0]  mul_x;
	logic [DST_W-1:0]  div_y;
	logic [DST_W-1:0]  div_x;
	logic              busy_y;
	logic              busy_x;
	logic [DIVN_W-1:0] quo_y;
	logic [DIVN_W-1:0] quo_x;

	logic [S_W-1:0]       s_y;
	logic [S_W-1:0]       s_x;
	logic [FL_W-1:0]      fl_y_q;
	logic [FL_W-1:0]      fl_x_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic [FRAC_BITS-1:0] fx_q;

	logic [LIM_W-1:0] lim_h;
	logic [LIM_W-1:0] lim_w;
	logic [FL_W-1:0]  y1;
	logic [FL_W-1:0]  x1;

	logic              rv0_q, rv1_q, cv0_q, cv1_q;
	logic [ROW_AW-1:0] y0i_q, y1i_q;
	logic [COL_AW-1:0] x0i_q, x1i_q;
	logic [WGT_W-1:0]  wy0_q, wy1_q, wx0_q, wx1_q;

	logic [2:0]        k_q;
	logic [1:0]        ks;
	logic [ROW_AW-1:0] rd_row;
	logic [COL_AW-1:0] rd_col;
	logic [FS_AW-1:0]  raddr;
	logic [FS_AW-1:0]  waddr;
	logic [PIX_W-1:0]  rdata;

	logic              v_s1;
	logic              nv_s1;
	logic [WP_W-1:0]   w_s1;
	logic              v_s2;
	logic [ACC_W-1:0]  prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  rnd;
	logic [ACC_W-2*FRAC_BITS-1:0] res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_height_q <= SRC_W'(256);
			src_width_q  <= SRC_W'(256);
			dst_height_q <= DST_W'(256);
			dst_width_q  <= DST_W'(256);
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_W-1:0];
				REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[DST_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[DST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_q);
			REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_q);
			default:        prdata = '0;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (action == ACT_LOAD)
		&& ({1'b0, row} < (POS_W+1)'(MAX_SRC_HEIGHT))
		&& ({1'b0, col} < (POS_W+1)'(MAX_SRC_WIDTH));
	assign waddr  = FS_AW'(32'(row[ROW_AW-1:0]) * MAX_SRC_WIDTH + 32'(col[COL_AW-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			v_s1 <= (state_q == ST_READ) && !k_q[2];
			v_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_COMPUTE)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV: begin
					if (!busy_y && !busy_x) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP:  state_q <= ST_EDGE;
				ST_EDGE: begin
					k_q     <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row;
			col_q <= col;
		end
	end

	assign mul_y = MUL_W'({row_q, 1'b1}) * MUL_W'(src_height_q);
	assign mul_x = MUL_W'({col_q, 1'b1}) * MUL_W'(src_width_q);
	assign div_y = (dst_height_q == '0) ? DST_W'(1) : dst_height_q;
	assign div_x = (dst_width_q == '0) ? DST_W'(1) : dst_width_q;

	bir_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (state_q == ST_MUL),
		.dividend (DIVN_W'(mul_y) << (FRAC_BITS - 1)),
		.divisor  (div_y),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	bir_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (state_q == ST_MUL),
		.dividend (DIVN_W'(mul_x) << (FRAC_BITS - 1)),
		.divisor  (div_x),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	assign s_y = {1'b0, quo_y} - (S_W'(1) << (FRAC_BITS - 1));
	assign s_x = {1'b0, quo_x} - (S_W'(1) << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			fl_y_q <= s_y[S_W-1:FRAC_BITS];
			fl_x_q <= s_x[S_W-1:FRAC_BITS];
			fy_q   <= s_y[FRAC_BITS-1:0];
			fx_q   <= s_x[FRAC_BITS-1:0];
		end
	end

	assign lim_h = ({4'b0, src_height_q} > LIM_W'(MAX_SRC_HEIGHT)) ?
		LIM_W'(MAX_SRC_HEIGHT) : LIM_W'(src_height_q);
	assign lim_w = ({4'b0, src_width_q} > LIM_W'(MAX_SRC_WIDTH)) ?
		LIM_W'(MAX_SRC_WIDTH) : LIM_W'(src_width_q);
	assign y1 = fl_y_q + 1'b1;
	assign x1 = fl_x_q + 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE) begin
			rv0_q <= !fl_y_q[FL_W-1] && (fl_y_q < FL_W'(lim_h));
			rv1_q <= !y1[FL_W-1] && (y1 < FL_W'(lim_h));
			cv0_q <= !fl_x_q[FL_W-1] && (fl_x_q < FL_W'(lim_w));
			cv1_q <= !x1[FL_W-1] && (x1 < FL_W'(lim_w));
			y0i_q <= fl_y_q[ROW_AW-1:0];
			y1i_q <= y1[ROW_AW-1:0];
			x0i_q <= fl_x_q[COL_AW-1:0];
			x1i_q <= x1[COL_AW-1:0];
			wy1_q <= {1'b0, fy_q};
			wy0_q <= (WGT_W'(1) << FRAC_BITS) - {1'b0, fy_q};
			wx1_q <= {1'b0, fx_q};
			wx0_q <= (WGT_W'(1) << FRAC_BITS) - {1'b0, fx_q};
		end
	end

	assign ks     = k_q[1:0];
	assign rd_row = ks[1] ? y1i_q : y0i_q;
	assign rd_col = ks[0] ? x1i_q : x0i_q;
	assign raddr  = FS_AW'(32'(rd_row) * MAX_SRC_WIDTH + 32'(rd_col));

	bir_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FS_DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (pixel_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		w_s1    <= WP_W'(ks[1] ? wy1_q : wy0_q) * WP_W'(ks[0] ? wx1_q : wx0_q);
		nv_s1   <= (ks[1] ? rv1_q : rv0_q) && (ks[0] ? cv1_q : cv0_q);
		prod_s2 <= ACC_W'(nv_s1 ? rdata : '0) * ACC_W'(w_s1);
		if (state_q == ST_EDGE) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign rnd = acc_q + (ACC_W'(1) << (2 * FRAC_BITS - 1));
	assign res = rnd[ACC_W-1:2*FRAC_BITS];

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			pixel_out <= (res > {{(ACC_W-2*FRAC_BITS-PIX_W){1'b0}}, {PIX_W{1'b1}}}) ?
				{PIX_W{1'b1}} : res[PIX_W-1:0];
		end
	end

endmodule

### dv/bilinear_resize_checker.sv
module bilinear_resize_checker
	import bir_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic               action,
	input  logic [POS_W-1:0]   row,
	input  logic [POS_W-1:0]   col,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic               done,
	input  logic [PIX_W-1:0]   pixel_out,
	output int                 mismatches,
	output int                 outstanding,
	output int                 compared
);

	logic [PIX_W-1:0] source_image [FS_DEPTH];
	logic [SRC_W-1:0] src_h, src_w;
	logic [DST_W-1:0] dst_h, dst_w;
	logic [PIX_W-1:0] expected_pixels [$];
	logic [PIX_W-1:0] want;

	function automatic longint source_coord(longint c, longint src, longint dst);
		longint d;
		d = (dst == 0) ? 1 : dst;
		return (((2 * c + 1) * src) << FRAC_BITS) / (2 * d) - (64'sd1 << (FRAC_BITS - 1));
	endfunction

	function automatic longint sample(longint r, longint c, longint h, longint w);
		if (r < 0 || c < 0 || r >= h || c >= w)
			return 0;
		return longint'(source_image[r * MAX_SRC_WIDTH + c]);
	endfunction

	function automatic logic [PIX_W-1:0] interpolate_pixel(logic [POS_W-1:0] r,
			logic [POS_W-1:0] c);
		longint sy, sx, y0, x0, fy, fx, h, w, one, sum;
		one = 64'sd1 << FRAC_BITS;
		h = (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : longint'(src_h);
		w = (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : longint'(src_w);
		sy = source_coord(longint'(r), longint'(src_h), longint'(dst_h));
		sx = source_coord(longint'(c), longint'(src_w), longint'(dst_w));
		y0 = sy >>> FRAC_BITS;
		x0 = sx >>> FRAC_BITS;
		fy = sy & (one - 1);
		fx = sx & (one - 1);
		sum = sample(y0, x0, h, w) * (one - fx) * (one - fy)
			+ sample(y0, x0 + 1, h, w) * fx * (one - fy)
			+ sample(y0 + 1, x0, h, w) * (one - fx) * fy
			+ sample(y0 + 1, x0 + 1, h, w) * fx * fy;
		sum = (sum + (64'sd1 << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
		return (sum > 255) ? 8'd255 : PIX_W'(sum);
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches <= mismatches + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_h <= SRC_W'(256);
			src_w <= SRC_W'(256);
			dst_h <= DST_W'(256);
			dst_w <= DST_W'(256);
			expected_pixels.delete();
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_SRC_HEIGHT: src_h <= pwdata[SRC_W-1:0];
					REG_SRC_WIDTH:  src_w <= pwdata[SRC_W-1:0];
					REG_DST_HEIGHT: dst_h <= pwdata[DST_W-1:0];
					REG_DST_WIDTH:  dst_w <= pwdata[DST_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					flag_mismatch($sformatf("pixel_out %0d with no compute beat waiting",
						pixel_out));
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want)
						flag_mismatch($sformatf("pixel_out %0d, expected %0d",
							pixel_out, want));
					compared <= compared + 1;
				end
			end
			if (start && !busy) begin
				if (action == ACT_LOAD) begin
					if (row < MAX_SRC_HEIGHT && col < MAX_SRC_WIDTH)
						source_image[row * MAX_SRC_WIDTH + col] = pixel_in;
				end else begin
					expected_pixels.push_back(interpolate_pixel(row, col));
				end
			end
			outstanding <= expected_pixels.size();
		end
	end

endmodule

### dv/bilinear_image_resize_unit_test.sv
module bilinear_image_resize_unit_test;
	import bir_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic               action = ACT_LOAD;
	logic [POS_W-1:0]   row = '0;
	logic [POS_W-1:0]   col = '0;
	logic [PIX_W-1:0]   pixel_in = '0;
	logic               done;
	logic [PIX_W-1:0]   pixel_out;

	int mismatches, outstanding, compared;
	int items = 0;
	int computes = 0;
	int settings = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	bit loaded [MAX_SRC_HEIGHT][MAX_SRC_WIDTH];
	int src_h = 256, src_w = 256, dst_h = 256, dst_w = 256;

	bilinear_image_resize_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .row(row), .col(col),
		.pixel_in(pixel_in), .done(done), .pixel_out(pixel_out)
	);

	bilinear_resize_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .row(row), .col(col),
		.pixel_in(pixel_in), .done(done), .pixel_out(pixel_out),
		.mismatches(mismatches), .outstanding(outstanding), .compared(compared)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 4000) begin
			$display("Watchdog: no beat for %0d cycles", quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint source_floor(int c, int src, int dst);
		longint d;
		d = (dst == 0) ? 1 : dst;
		return ((((2 * longint'(c) + 1) * longint'(src)) << FRAC_BITS) / (2 * d)
			- (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	task automatic send_beat(logic act, int r, int c, logic [PIX_W-1:0] p);
		while (!steady && $urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		row <= POS_W'(r);
		col <= POS_W'(c);
		pixel_in <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (act == ACT_COMPUTE) begin
			computes++;
			items++;
		end else if (r < MAX_SRC_HEIGHT && c < MAX_SRC_WIDTH) begin
			items++;
		end
	endtask

	task automatic load_pixel(int r, int c, logic [PIX_W-1:0] p);
		if (r < MAX_SRC_HEIGHT && c < MAX_SRC_WIDTH)
			loaded[r][c] = 1'b1;
		send_beat(ACT_LOAD, r, c, p);
	endtask

	task automatic compute_at(int r, int c);
		longint y, x, i, j;
		int h, w;
		h = (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
		w = (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
		y = source_floor(r, src_h, dst_h);
		x = source_floor(c, src_w, dst_w);
		for (i = y; i <= y + 1; i++)
			for (j = x; j <= x + 1; j++)
				if (i >= 0 && j >= 0 && i < h && j < w && !loaded[i][j])
					load_pixel(int'(i), int'(j), PIX_W'($urandom_range(0, 255)));
		send_beat(ACT_COMPUTE, r, c, PIX_W'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(int sh, int sw, int dh, int dw);
		int vals [4];
		int i;
		vals = '{sh, sw, dh, dw};
		for (i = 0; i < 4; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= PADDR_W'({reg_idx_t'(i), 2'b00});
			pwdata <= PDATA_W'(vals[i]);
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		src_h = sh & 9'h1FF;
		src_w = sw & 9'h1FF;
		dst_h = dh & 13'h1FFF;
		dst_w = dw & 13'h1FFF;
		settings++;
	endtask

	function automatic int dst_index(int dst);
		if (dst == 0)
			return 0;
		return $urandom_range(0, (dst > 4096) ? 4095 : dst - 1);
	endfunction

	task automatic random_item();
		int pick, h, w;
		h = (src_h > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : src_h;
		w = (src_w > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : src_w;
		pick = $urandom_range(0, 99);
		if (pick < 52)
			compute_at(dst_index(dst_h), dst_index(dst_w));
		else if (pick < 60)
			compute_at($urandom_range(0, 4095), $urandom_range(0, 4095));
		else if (pick < 85)
			load_pixel($urandom_range(0, (h == 0) ? MAX_SRC_HEIGHT - 1 : h - 1),
				$urandom_range(0, (w == 0) ? MAX_SRC_WIDTH - 1 : w - 1),
				PIX_W'($urandom_range(0, 255)));
		else if (pick < 95)
			load_pixel($urandom_range(0, MAX_SRC_HEIGHT - 1),
				$urandom_range(0, MAX_SRC_WIDTH - 1), PIX_W'($urandom_range(0, 255)));
		else if ($urandom_range(0, 1) == 0)
			load_pixel($urandom_range(MAX_SRC_HEIGHT, 4095), $urandom_range(0, 4095),
				PIX_W'($urandom_range(0, 255)));
		else
			load_pixel($urandom_range(0, 4095), $urandom_range(MAX_SRC_WIDTH, 4095),
				PIX_W'($urandom_range(0, 255)));
	endtask

	initial begin
		int plan [6][4];
		int p, target;
		plan = '{
			'{4, 4, 16, 16},
			'{1, 1, 1, 1},
			'{511, 300, 8191, 0},
			'{0, 7, 5, 0},
			'{200, 256, 7, 4096},
			'{3, 5, 4095, 2}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_pixel(0, 0, 8'hFF);
		load_pixel(0, 1, 8'h00);
		load_pixel(1, 0, 8'hFF);
		load_pixel(1, 1, 8'h80);
		load_pixel(255, 255, 8'hFF);
		load_pixel(254, 254, 8'h00);
		load_pixel(256, 0, 8'hAA);
		load_pixel(0, 4095, 8'h55);
		load_pixel(4095, 4095, 8'hFF);
		compute_at(0, 0);
		compute_at(255, 255);
		compute_at(254, 254);
		compute_at(4095, 4095);
		compute_at(0, 4095);
		compute_at(4095, 0);
		compute_at(128, 128);
		load_pixel(0, 0, 8'h55);
		compute_at(0, 0);
		drain_results();

		for (p = 0; p < 12; p++) begin
			if (p < 6)
				configure(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
			else
				configure(
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48));
			steady = (p == 7);
			target = items + 130;
			while (items < target) begin
				random_item();
				if ($urandom_range(0, 99) == 0)
					drain_results();
			end
			drain_results();
		end
		steady = 1'b0;
		configure(256, 256, 256, 256);
		drain_results();

		$display("Covered %0d beats (%0d computes) over %0d register settings, from zero",
			items, computes, settings);
		$display("  source and destination sizes up to the field limits; %0d pixels compared.",
			compared);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
